FILE: src/crc32_clmul_fold_engine_core_macros.svh
// Assertion macros for the CRC-32 fold engine.
// Used by the top level; no other dependencies.
`ifndef CRC32_CLMUL_FOLD_ENGINE_CORE_MACROS_SVH
`define CRC32_CLMUL_FOLD_ENGINE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define CRCF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("crcfold assertion failed");
`define CRCF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("crcfold assertion failed");
`else
`define CRCF_ASSERT_IMP(lbl, ante, cons)
`define CRCF_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: src/crcfold_pkg.sv
// Shared types, folding constants and carry-less multiply helpers
// for the CRC-32 fold engine. No dependencies.
package crcfold_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam logic [32:0] K3   = 33'h1751997d0;
  localparam logic [32:0] K4   = 33'h0ccaa009e;
  localparam logic [32:0] K5   = 33'h163cd6124;
  localparam logic [32:0] MU   = 33'h1f7011641;
  localparam logic [32:0] POLY = 33'h1db710641;

  typedef struct packed {
    logic [63:0] data_low;
    logic [63:0] data_high;
    logic        first_block;
    logic        last_block;
    logic [31:0] seed;
  } crcfold_blk_t;

  typedef struct packed {
    logic reducing;
    logic out_full;
  } crcfold_bk_stat_t;

  typedef enum logic [2:0] {
    ST_FOLD,
    ST_R1,
    ST_R2,
    ST_R3,
    ST_R4
  } crcfold_state_t;

  function automatic logic [96:0] clmul_64x33(input logic [63:0] a, input logic [32:0] b);
    logic [96:0] acc;
    acc = '0;
    for (int i = 0; i < 33; i++) begin
      if (b[i]) begin
        acc = acc ^ ({33'd0, a} << i);
      end
    end
    return acc;
  endfunction

  function automatic logic [64:0] clmul_32x33(input logic [31:0] a, input logic [32:0] b);
    logic [64:0] acc;
    acc = '0;
    for (int i = 0; i < 33; i++) begin
      if (b[i]) begin
        acc = acc ^ ({33'd0, a} << i);
      end
    end
    return acc;
  endfunction

endpackage

FILE: src/crcfold_ifs.sv
// Valid/ready channel interfaces for blocks in and CRC words out.
// No dependencies.
interface crcfold_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_low;
  logic [63:0] data_high;
  logic        first_block;
  logic        last_block;
  logic [31:0] seed;

  modport source (output valid, data_low, data_high, first_block, last_block, seed,
                  input ready);
  modport sink   (input valid, data_low, data_high, first_block, last_block, seed,
                  output ready);
endinterface

interface crcfold_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] crc_state;

  modport source (output valid, crc_state, input ready);
  modport sink   (input valid, crc_state, output ready);
endinterface

FILE: src/crc32_clmul_fold_engine_core.sv
// Top level of the CRC-32 carry-less multiply fold engine.
// Depends on crcfold_pkg, crcfold_ifs, crcfold_front, crcfold_back and the macros header.
//
//  channel  | dir | words                                   | handshake
//  in_blk   | in  | data_low, data_high, first/last, seed   | valid/ready
//  out_crc  | out | crc_state, one per last block           | valid/ready
//
// Each block is folded by the fold unit (two constant carry-less products and
// XOR; a first block instead loads its data XOR seed); a last block then holds
// the fold unit for the fold and four reduction steps (k4, k5, mu, polynomial).
// The result sits in an output register; the reduction waits in its final
// step while that register is still full. The input queue absorbs up to
// QUEUE_DEPTH words while the back end reduces or waits; once it is full,
// in_blk.ready drops until the fold unit pops a word.
// Reset clears the queue, the accumulator and the output valid flag.
`include "crc32_clmul_fold_engine_core_macros.svh"
module crc32_clmul_fold_engine_core
  import crcfold_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  crcfold_in_if.sink    in_blk,
  crcfold_out_if.source out_crc
);

  crcfold_blk_t     q_blk;
  logic             q_valid;
  logic             q_pop;
  crcfold_bk_stat_t bk_stat;

  crcfold_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_blk (in_blk),
    .q_blk  (q_blk),
    .q_valid(q_valid),
    .q_pop  (q_pop)
  );

  crcfold_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_blk  (q_blk),
    .q_valid(q_valid),
    .q_pop  (q_pop),
    .out_crc(out_crc),
    .stat   (bk_stat)
  );

  `CRCF_ASSERT_IMP(a_pop_needs_data, q_pop, q_valid && !bk_stat.reducing)
  `CRCF_ASSERT_NXT(a_last_starts_reduce, q_pop && q_blk.last_block, bk_stat.reducing)
  `CRCF_ASSERT_IMP(a_result_from_reduce, $rose(out_crc.valid), $past(bk_stat.reducing))

endmodule

FILE: src/crcfold_front.sv
// Front end: accepts block words and queues them for the fold unit.
// Depends on crcfold_pkg and crcfold_in_if.
module crcfold_front
  import crcfold_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  crcfold_in_if.sink          in_blk,
  output crcfold_blk_t        q_blk,
  output logic                q_valid,
  input  logic                q_pop
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  crcfold_blk_t     mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             push;
  crcfold_blk_t     wr_blk;

  assign in_blk.ready = (cnt_r != CNT_FULL);
  assign push         = in_blk.valid && in_blk.ready;
  assign q_valid      = (cnt_r != '0);
  assign q_blk        = mem_r[rd_ptr_r];

  always_comb begin
    wr_blk.data_low    = in_blk.data_low;
    wr_blk.data_high   = in_blk.data_high;
    wr_blk.first_block = in_blk.first_block;
    wr_blk.last_block  = in_blk.last_block;
    wr_blk.seed        = in_blk.seed;
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_blk;
    end
  end

endmodule

FILE: src/crcfold_back.sv
// Back end: folds queued blocks into the 128-bit accumulator and runs the
// final 128->32 reduction. Depends on crcfold_pkg and crcfold_out_if.
module crcfold_back
  import crcfold_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  crcfold_blk_t      q_blk,
  input  logic              q_valid,
  output logic              q_pop,
  crcfold_out_if.source     out_crc,
  output crcfold_bk_stat_t  stat
);

  crcfold_state_t state_r, state_nxt;
  logic [63:0]    acc_lo_r, acc_lo_nxt;
  logic [63:0]    acc_hi_r, acc_hi_nxt;
  logic [95:0]    s1_r;
  logic [63:0]    s2_r;
  logic [31:0]    t_r;
  logic [31:0]    crc_r;
  logic           out_valid_r, out_valid_nxt;
  logic           out_load;
  logic [96:0]    f3, f4, r1;
  logic [64:0]    r2, r3, r4;

  assign f3 = clmul_64x33(acc_lo_r, K3);
  assign f4 = clmul_64x33(acc_hi_r, K4);
  assign r1 = clmul_64x33(acc_lo_r, K4);
  assign r2 = clmul_32x33(s1_r[31:0], K5);
  assign r3 = clmul_32x33(s2_r[31:0], MU);
  assign r4 = clmul_32x33(t_r, POLY);

  assign out_crc.valid     = out_valid_r;
  assign out_crc.crc_state = crc_r;
  assign stat.reducing     = (state_r != ST_FOLD);
  assign stat.out_full     = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    acc_lo_nxt    = acc_lo_r;
    acc_hi_nxt    = acc_hi_r;
    q_pop         = 1'b0;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r && !out_crc.ready;
    unique case (state_r)
      ST_FOLD: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_blk.first_block) begin
            acc_lo_nxt = q_blk.data_low ^ {32'd0, q_blk.seed};
            acc_hi_nxt = q_blk.data_high;
          end else begin
            acc_lo_nxt = f3[63:0] ^ f4[63:0] ^ q_blk.data_low;
            acc_hi_nxt = {31'd0, f3[96:64]} ^ {31'd0, f4[96:64]} ^ q_blk.data_high;
          end
          if (q_blk.last_block) begin
            state_nxt = ST_R1;
          end
        end
      end
      ST_R1: state_nxt = ST_R2;
      ST_R2: state_nxt = ST_R3;
      ST_R3: state_nxt = ST_R4;
      ST_R4: begin
        if (!out_valid_r || out_crc.ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_FOLD;
        end
      end
      default: state_nxt = ST_FOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FOLD;
      acc_lo_r    <= '0;
      acc_hi_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_lo_r    <= acc_lo_nxt;
      acc_hi_r    <= acc_hi_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_R1) begin
      s1_r <= {r1[95:64], r1[63:0] ^ acc_hi_r};
    end
    if (state_r == ST_R2) begin
      s2_r <= r2[63:0] ^ s1_r[95:32];
    end
    if (state_r == ST_R3) begin
      t_r <= r3[31:0];
    end
    if (out_load) begin
      crc_r <= r4[63:32] ^ s2_r[63:32];
    end
  end

endmodule

FILE: tb/crcfold_crc_checker.sv
// Scoreboard for the CRC-32 fold engine: watches the block and CRC channels,
// folds every accepted block word into its own accumulator and checks each CRC word.
// Depends on crcfold_pkg and crcfold_ifs.
module crcfold_crc_checker
  import crcfold_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  crcfold_in_if  blk_mon,
  crcfold_out_if crc_mon,
  output int     mismatches,
  output int     crcs_due
);

  localparam logic [63:0] FOLD_K3    = 64'h0000_0001_7519_97d0;
  localparam logic [63:0] FOLD_K4    = 64'h0000_0000_ccaa_009e;
  localparam logic [63:0] FOLD_K5    = 64'h0000_0001_63cd_6124;
  localparam logic [63:0] BARRETT_MU = 64'h0000_0001_f701_1641;
  localparam logic [63:0] CRC_POLY   = 64'h0000_0001_db71_0641;

  logic [127:0] fold_acc;
  logic [31:0]  crc_queue[$];
  logic [31:0]  crc_want;
  crcfold_blk_t blk_word;
  int           crc_errors;

  function automatic logic [127:0] gf2_mul64(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    prod = '0;
    for (int i = 0; i < 64; i++) begin
      if (b[i]) begin
        prod = prod ^ ({64'd0, a} << i);
      end
    end
    return prod;
  endfunction

  function automatic logic [127:0] fold_word(input logic [127:0] acc, input crcfold_blk_t blk);
    logic [127:0] p_lo;
    logic [127:0] p_hi;
    if (blk.first_block) begin
      return {blk.data_high, blk.data_low ^ {32'd0, blk.seed}};
    end
    p_lo = gf2_mul64(acc[63:0], FOLD_K3);
    p_hi = gf2_mul64(acc[127:64], FOLD_K4);
    return p_lo ^ p_hi ^ {blk.data_high, blk.data_low};
  endfunction

  function automatic logic [31:0] reduce_to_crc(input logic [127:0] acc);
    logic [127:0] s;
    logic [127:0] t;
    s = gf2_mul64(acc[63:0], FOLD_K4) ^ {64'd0, acc[127:64]};
    s = gf2_mul64({32'd0, s[31:0]}, FOLD_K5) ^ (s >> 32);
    t = gf2_mul64({32'd0, s[31:0]}, BARRETT_MU);
    t = gf2_mul64({32'd0, t[31:0]}, CRC_POLY);
    return t[63:32] ^ s[63:32];
  endfunction

  task automatic flag_error(input string msg);
    crc_errors++;
    if (crc_errors <= 10) begin
      $display("%0t: %s", $realtime, msg);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      fold_acc = '0;
      crc_queue.delete();
      crc_errors = 0;
    end else begin
      if (crc_mon.valid && crc_mon.ready) begin
        if (crc_queue.size() == 0) begin
          flag_error($sformatf("unexpected crc word %h", crc_mon.crc_state));
        end else begin
          crc_want = crc_queue.pop_front();
          if (crc_mon.crc_state !== crc_want) begin
            flag_error($sformatf("crc_state expected %h got %h", crc_want, crc_mon.crc_state));
          end
        end
      end
      if (blk_mon.valid && blk_mon.ready) begin
        blk_word.data_low    = blk_mon.data_low;
        blk_word.data_high   = blk_mon.data_high;
        blk_word.first_block = blk_mon.first_block;
        blk_word.last_block  = blk_mon.last_block;
        blk_word.seed        = blk_mon.seed;
        fold_acc = fold_word(fold_acc, blk_word);
        if (blk_word.last_block) begin
          crc_queue.push_back(reduce_to_crc(fold_acc));
        end
      end
    end
    mismatches <= crc_errors;
    crcs_due   <= crc_queue.size();
  end

endmodule

FILE: tb/crc32_clmul_fold_engine_core_test.sv
// Top of the CRC-32 fold engine test: clock, reset, block and CRC channel drivers.
// Drives directed then random message words with random gaps and stalls; the verdict
// comes from crcfold_crc_checker. Depends on crcfold_pkg, crcfold_ifs and the engine.
module crc32_clmul_fold_engine_core_test;
  import crcfold_pkg::*;

  localparam int RANDOM_WORDS = 1950;
  localparam int LONG_HOLD    = 400;
  localparam int HOLD_AT_CRC  = 40;

  logic clk;
  logic rst_n;
  int   mismatches;
  int   crcs_due;
  int   words_sent;
  int   crcs_taken;
  int   directed_words;

  crcfold_in_if  blk_ch();
  crcfold_out_if crc_ch();

  crc32_clmul_fold_engine_core DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_blk  (blk_ch),
    .out_crc (crc_ch)
  );

  crcfold_crc_checker scoreboard (
    .clk        (clk),
    .rst_n      (rst_n),
    .blk_mon    (blk_ch),
    .crc_mon    (crc_ch),
    .mismatches (mismatches),
    .crcs_due   (crcs_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [63:0] rand_word64();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  function automatic logic [31:0] rand_seed();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_block(input logic [63:0] lo, input logic [63:0] hi,
                            input logic first, input logic last, input logic [31:0] seed);
    int gap;
    gap = ((words_sent / 64) % 3 == 1) ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      blk_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    blk_ch.valid       <= 1'b1;
    blk_ch.data_low    <= lo;
    blk_ch.data_high   <= hi;
    blk_ch.first_block <= first;
    blk_ch.last_block  <= last;
    blk_ch.seed        <= seed;
    @(posedge clk);
    while (!blk_ch.ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_message(input int blocks, input logic seeded, input logic closed);
    for (int b = 0; b < blocks; b++) begin
      send_block(rand_word64(), rand_word64(), seeded && b == 0, closed && b == blocks - 1,
                 rand_seed());
    end
  endtask

  initial begin
    int msg_len;
    rst_n              <= 1'b0;
    blk_ch.valid       <= 1'b0;
    blk_ch.data_low    <= '0;
    blk_ch.data_high   <= '0;
    blk_ch.first_block <= 1'b0;
    blk_ch.last_block  <= 1'b0;
    blk_ch.seed        <= '0;
    words_sent = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // fold from the cleared accumulator without a first word
    send_block('1, '0, 1'b0, 1'b0, '1);
    send_block(64'h0123_4567_89ab_cdef, '1, 1'b0, 1'b1, '0);
    send_block('0, '0, 1'b1, 1'b1, '0);
    send_block('1, '1, 1'b1, 1'b1, '1);
    send_block('1, '0, 1'b1, 1'b1, '0);
    send_block('0, '1, 1'b1, 1'b1, '1);
    send_block('0, '0, 1'b1, 1'b1, '1);
    send_block(64'h3837_3635_3433_3231, 64'h3635_3433_3231_3039, 1'b1, 1'b1, '1);
    // continue folding past a result
    send_block(rand_word64(), rand_word64(), 1'b0, 1'b1, rand_seed());
    send_block(rand_word64(), rand_word64(), 1'b1, 1'b0, rand_seed());
    send_block(rand_word64(), rand_word64(), 1'b0, 1'b0, rand_seed());
    send_block(rand_word64(), rand_word64(), 1'b0, 1'b1, rand_seed());
    // restart a message before its last word
    send_block(rand_word64(), rand_word64(), 1'b1, 1'b0, rand_seed());
    send_block(rand_word64(), rand_word64(), 1'b1, 1'b0, rand_seed());
    send_block(rand_word64(), rand_word64(), 1'b0, 1'b1, rand_seed());
    send_block(64'h8000_0000_0000_0001, 64'h8000_0000_0000_0001, 1'b1, 1'b1, 32'h8000_0001);
    directed_words = words_sent;

    while (words_sent < directed_words + RANDOM_WORDS) begin
      msg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 32) : $urandom_range(1, 8);
      case ($urandom_range(0, 15))
        0, 1: send_block(rand_word64(), rand_word64(), $urandom_range(0, 1) != 0,
                         $urandom_range(0, 1) != 0, rand_seed());
        2: send_message(msg_len, 1'b0, 1'b1);
        3: send_message(msg_len, 1'b1, 1'b0);
        default: send_message(msg_len, 1'b1, 1'b1);
      endcase
    end
    blk_ch.valid <= 1'b0;

    @(posedge clk);
    while (crcs_due != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && crcs_due == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    int stall;
    crc_ch.ready <= 1'b0;
    crcs_taken = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (crcs_taken == HOLD_AT_CRC) begin
        stall = LONG_HOLD;
      end else if ((crcs_taken / 32) % 3 == 1) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 19);
      end
      if (stall != 0) begin
        crc_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      crc_ch.ready <= 1'b1;
      @(posedge clk);
      while (!crc_ch.valid) @(posedge clk);
      crcs_taken++;
    end
  end

endmodule
